/* hw/rtl/jpa_pkg.sv */
`default_nettype none

package jpa_pkg;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 9;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_AUTOFIRE_ON   = 2'd0,
      CSR_BULLET_COUNT  = 2'd1,
      CSR_SHOT_INTERVAL = 2'd2,
      CSR_PORT_NUMBER   = 2'd3
   } csr_addr_type;

   typedef enum logic [3:0] {
      EV_UP           = 4'd0,
      EV_DOWN         = 4'd1,
      EV_LEFT         = 4'd2,
      EV_RIGHT        = 4'd3,
      EV_RELEASE_X    = 4'd4,
      EV_RELEASE_Y    = 4'd5,
      EV_RELEASE_BOTH = 4'd6,
      EV_PRESS_FIRE   = 4'd7,
      EV_RELEASE_FIRE = 4'd8
   } event_code_type;

   localparam logic MODE_EVENT = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // two's complement axis position
   localparam logic [1:0] AXIS_CENTER = 2'b00;
   localparam logic [1:0] AXIS_PLUS   = 2'b01;
   localparam logic [1:0] AXIS_MINUS  = 2'b11;

   localparam logic [15:0] JOY_LEFT  = 16'h0300;
   localparam logic [15:0] JOY_RIGHT = 16'h0003;
   localparam logic [15:0] JOY_UP    = 16'h0100;
   localparam logic [15:0] JOY_DOWN  = 16'h0001;

   localparam logic [7:0] CIA_FIRE_PORT1 = 8'hBF;
   localparam logic [7:0] CIA_FIRE_PORT2 = 8'h7F;
   localparam logic [7:0] CIA_IDLE       = 8'hFF;

   localparam logic [1:0] PORT_ONE = 2'd1;

   localparam logic [8:0] BULLET_COUNT_RESET = 9'h1FF;

   typedef struct packed {
      logic       valid;
      logic       mode;
      logic [3:0] event_code;
   } step_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic [15:0] joy_word;
      logic [7:0]  cia_byte;
      logic        fire_level;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/jpa_if.sv */
`default_nettype none

interface jpa_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [3:0] event_code;

   modport source (output valid, output mode, output event_code, input ready);
   modport sink   (input valid, input mode, input event_code, output ready);
endinterface

interface jpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] joy_word;
   logic [7:0]  cia_byte;
   logic        fire_level;

   modport source (output valid, output joy_word, output cia_byte, output fire_level,
                   input ready);
   modport sink   (input valid, input joy_word, input cia_byte, input fire_level,
                   output ready);
endinterface

interface jpa_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] addr;
   logic [8:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/jpa_state.sv */
`default_nettype none

module jpa_state
   import jpa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire step_type   step,
   input  wire csr_wr_type csr_wr,
   output result_type      result
);

   logic       autofire_on_ff,   autofire_on_in;
   logic [8:0] bullet_count_ff,  bullet_count_in;
   logic [7:0] shot_interval_ff, shot_interval_in;
   logic [1:0] port_number_ff,   port_number_in;

   logic [1:0] axis_h_ff,        axis_h_in;
   logic [1:0] axis_v_ff,        axis_v_in;
   logic       fire_pressed_ff,  fire_pressed_in;
   logic [7:0] bullets_left_ff,  bullets_left_in;
   logic       unlimited_ff,     unlimited_in;
   logic [7:0] frames_ff,        frames_in;

   always_comb begin
      logic [7:0] frames_dec;
      logic [15:0] word;

      autofire_on_in   = autofire_on_ff;
      bullet_count_in  = bullet_count_ff;
      shot_interval_in = shot_interval_ff;
      port_number_in   = port_number_ff;
      axis_h_in        = axis_h_ff;
      axis_v_in        = axis_v_ff;
      fire_pressed_in  = fire_pressed_ff;
      bullets_left_in  = bullets_left_ff;
      unlimited_in     = unlimited_ff;
      frames_in        = frames_ff;
      frames_dec       = frames_ff - 8'd1;

      if (csr_wr.valid) begin
         unique case (csr_addr_type'(csr_wr.addr))
            CSR_AUTOFIRE_ON: begin
               autofire_on_in = csr_wr.data[0];
               if (!csr_wr.data[0]) begin
                  fire_pressed_in = 1'b0;
               end
            end
            CSR_BULLET_COUNT: begin
               bullet_count_in = csr_wr.data;
               // reload only while a magazine is still in use
               if (bullets_left_ff != 8'd0 || unlimited_ff) begin
                  unlimited_in    = csr_wr.data[8];
                  bullets_left_in = csr_wr.data[8] ? 8'd0 : csr_wr.data[7:0];
               end
            end
            CSR_SHOT_INTERVAL: shot_interval_in = csr_wr.data[7:0];
            CSR_PORT_NUMBER:   port_number_in   = csr_wr.data[1:0];
            default: ;
         endcase
      end

      if (step.valid) begin
         if (step.mode == MODE_TICK) begin
            if (autofire_on_ff && shot_interval_ff != 8'd0 && frames_ff != 8'd0) begin
               frames_in = frames_dec;
               if (frames_dec == 8'd0 && (bullets_left_ff != 8'd0 || unlimited_ff)) begin
                  fire_pressed_in = !fire_pressed_ff;
                  if (fire_pressed_ff && !unlimited_ff) begin
                     bullets_left_in = bullets_left_ff - 8'd1;
                  end
                  frames_in = shot_interval_ff;
               end
            end
         end else begin
            unique case (event_code_type'(step.event_code))
               EV_UP:           axis_v_in = AXIS_MINUS;
               EV_DOWN:         axis_v_in = AXIS_PLUS;
               EV_LEFT:         axis_h_in = AXIS_MINUS;
               EV_RIGHT:        axis_h_in = AXIS_PLUS;
               EV_RELEASE_X:    axis_h_in = AXIS_CENTER;
               EV_RELEASE_Y:    axis_v_in = AXIS_CENTER;
               EV_RELEASE_BOTH: begin
                  axis_h_in = AXIS_CENTER;
                  axis_v_in = AXIS_CENTER;
               end
               EV_PRESS_FIRE: begin
                  if (!autofire_on_ff) begin
                     fire_pressed_in = 1'b1;
                  end else if (bullets_left_ff != 8'd0 || unlimited_ff) begin
                     // cease fire: empty the magazine
                     bullets_left_in = 8'd0;
                     unlimited_in    = 1'b0;
                     fire_pressed_in = 1'b0;
                  end else begin
                     unlimited_in    = bullet_count_ff[8];
                     bullets_left_in = bullet_count_ff[8] ? 8'd0 : bullet_count_ff[7:0];
                     fire_pressed_in = 1'b1;
                     frames_in       = shot_interval_ff;
                  end
               end
               EV_RELEASE_FIRE: begin
                  if (!autofire_on_ff) begin
                     fire_pressed_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end

      word = 16'h0000;
      if (axis_h_in == AXIS_MINUS) begin
         word = JOY_LEFT;
      end else if (axis_h_in == AXIS_PLUS) begin
         word = JOY_RIGHT;
      end
      if (axis_v_in == AXIS_MINUS) begin
         word = word ^ JOY_UP;
      end else if (axis_v_in == AXIS_PLUS) begin
         word = word ^ JOY_DOWN;
      end

      result.joy_word   = word;
      result.fire_level = fire_pressed_in;
      result.cia_byte   = !fire_pressed_in ? CIA_IDLE :
                          (port_number_in == PORT_ONE) ? CIA_FIRE_PORT1 : CIA_FIRE_PORT2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         autofire_on_ff   <= 1'b0;
         bullet_count_ff  <= BULLET_COUNT_RESET;
         shot_interval_ff <= 8'd0;
         port_number_ff   <= PORT_ONE;
         axis_h_ff        <= AXIS_CENTER;
         axis_v_ff        <= AXIS_CENTER;
         fire_pressed_ff  <= 1'b0;
         bullets_left_ff  <= 8'd0;
         unlimited_ff     <= 1'b0;
         frames_ff        <= 8'd0;
      end else begin
         autofire_on_ff   <= autofire_on_in;
         bullet_count_ff  <= bullet_count_in;
         shot_interval_ff <= shot_interval_in;
         port_number_ff   <= port_number_in;
         axis_h_ff        <= axis_h_in;
         axis_v_ff        <= axis_v_in;
         fire_pressed_ff  <= fire_pressed_in;
         bullets_left_ff  <= bullets_left_in;
         unlimited_ff     <= unlimited_in;
         frames_ff        <= frames_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/joystick_port_autofire_unit.sv */
// Emulated joystick port with autofire. Each req beat is a joystick event or one frame
// tick; each produces exactly one rsp beat with the JOYDAT word, CIA port A byte and
// button level as they stand after that beat. Throughput is one beat per clock while rsp
// is not stalled: the state update is a single combinational pass into the rsp output
// register, and req stays ready whenever that register is empty or being drained.
// CSR writes are always ready and take effect on the next clock; issue them only while
// no beat is in flight.
`default_nettype none

module joystick_port_autofire_unit
   import jpa_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   jpa_req_if.sink   req_chan,
   jpa_rsp_if.source rsp_chan,
   jpa_csr_if.sink   csr_chan
);

   step_type   step;
   csr_wr_type csr_wr;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_ready;

   assign req_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready  = req_ready;
   assign csr_chan.ready  = 1'b1;

   assign step.valid      = req_chan.valid && req_ready;
   assign step.mode       = req_chan.mode;
   assign step.event_code = req_chan.event_code;

   assign csr_wr.valid    = csr_chan.valid;
   assign csr_wr.addr     = csr_chan.addr;
   assign csr_wr.data     = csr_chan.data;

   jpa_state u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .csr_wr (csr_wr),
      .result (result)
   );

   assign rsp_valid_in = step.valid || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.joy_word   = rsp_data_ff.joy_word;
   assign rsp_chan.cia_byte   = rsp_data_ff.cia_byte;
   assign rsp_chan.fire_level = rsp_data_ff.fire_level;

endmodule

`default_nettype wire

/* hw/rtl/jpa_checker.sv */
`default_nettype none

module jpa_checker
   import jpa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_joy_word,
   input wire logic [7:0]  rsp_cia_byte,
   input wire logic        rsp_fire_level
);

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_joy_word)
         && $stable(rsp_cia_byte) && $stable(rsp_fire_level))
      else $error("rsp beat changed while stalled");

   // every accepted req beat shows up as a rsp beat in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted req beat produced no rsp beat");

   a_fire_cia: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fire_level == (rsp_cia_byte != CIA_IDLE))
         && (rsp_cia_byte == CIA_IDLE || rsp_cia_byte == CIA_FIRE_PORT1
             || rsp_cia_byte == CIA_FIRE_PORT2))
      else $error("cia byte disagrees with fire level");

   a_joy_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_joy_word[7:2] == 6'd0 && rsp_joy_word[15:10] == 6'd0)
      else $error("joy word has stray counter bits");

endmodule

bind joystick_port_autofire_unit jpa_checker u_jpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_joy_word   (rsp_chan.joy_word),
   .rsp_cia_byte   (rsp_chan.cia_byte),
   .rsp_fire_level (rsp_chan.fire_level)
);

`default_nettype wire
